// ===== rtl/xte_pkg.sv =====
// Shared types, constants and text tables for the XML text escaper.
`timescale 1ns / 1ps

package xte_pkg;

  // Default number of classified items held between the front and the back.
  localparam int XTE_QUEUE_DEPTH = 2;

  // Longest run of output bytes one input item can cause.
  localparam int XTE_MAX_RUN = 12;

  // Character codes the classifier tests against.
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;

  // How an accepted item is to be written out.
  typedef enum logic [3:0] {
    KIND_PASS,
    KIND_BR,
    KIND_NL_ATTR,
    KIND_LT,
    KIND_GT,
    KIND_AMP,
    KIND_APOS,
    KIND_QUOT,
    KIND_HEX
  } xte_kind_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    xte_kind_t  kind;
    logic [7:0] chr;
  } xte_entry_t;

  // Entity texts, left-justified in a 12-byte buffer.
  localparam logic [95:0] TXT_BR   = {"<br/>", 56'h0};
  localparam logic [95:0] TXT_NL   = {"&#10;", 56'h0};
  localparam logic [95:0] TXT_LT   = {"&lt;", 64'h0};
  localparam logic [95:0] TXT_GT   = {"&gt;", 64'h0};
  localparam logic [95:0] TXT_AMP  = {"&amp;", 56'h0};
  localparam logic [95:0] TXT_APOS = {"&apos;", 48'h0};
  localparam logic [95:0] TXT_QUOT = {"&quot;", 48'h0};

  // Number of output bytes an item of the given kind produces.
  function automatic logic [3:0] run_len(input xte_kind_t kind);
    logic [3:0] len;
    case (kind)
      KIND_PASS:    len = 4'd1;
      KIND_BR:      len = 4'd5;
      KIND_NL_ATTR: len = 4'd5;
      KIND_LT:      len = 4'd4;
      KIND_GT:      len = 4'd4;
      KIND_AMP:     len = 4'd5;
      KIND_APOS:    len = 4'd6;
      KIND_QUOT:    len = 4'd6;
      KIND_HEX:     len = 4'd12;
      default:      len = 4'd1;
    endcase
    return len;
  endfunction

  // Lower-case ASCII hex digit for one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'h0, nib};
    end else begin
      d = 8'h57 + {4'h0, nib};
    end
    return d;
  endfunction

  // Full output text of an item, left-justified in a 12-byte buffer.
  function automatic logic [95:0] run_text(input xte_entry_t ent);
    logic [95:0] txt;
    case (ent.kind)
      KIND_PASS:    txt = {ent.chr, 88'h0};
      KIND_BR:      txt = TXT_BR;
      KIND_NL_ATTR: txt = TXT_NL;
      KIND_LT:      txt = TXT_LT;
      KIND_GT:      txt = TXT_GT;
      KIND_AMP:     txt = TXT_AMP;
      KIND_APOS:    txt = TXT_APOS;
      KIND_QUOT:    txt = TXT_QUOT;
      KIND_HEX:     txt = {"&lt;0x", hex_digit(ent.chr[7:4]), hex_digit(ent.chr[3:0]), "&gt;"};
      default:      txt = {ent.chr, 88'h0};
    endcase
    return txt;
  endfunction

  // Byte at position idx of an item's output text.
  function automatic logic [7:0] run_byte(input xte_entry_t ent, input logic [3:0] idx);
    logic [95:0] txt;
    logic [6:0]  shamt;
    txt   = run_text(ent);
    shamt = {4'(4'd11 - idx), 3'b000};
    return 8'(txt >> shamt);
  endfunction

endpackage

// ===== rtl/xml_text_escaper_top.sv =====
// Top level of the XML text escaper: front end, item queue and back end.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_ready) takes one byte of a string per item,
// with in_string_start high on the first byte of each string. The output
// channel (out_valid/out_ready) gives the escaped text one byte per item, with
// out_run_last high on the last byte caused by each input byte; a dropped
// CR/LF produces no output at all. cfg_wr_en/cfg_wr_data write the attribute
// mode bit at any clock edge; change it only while the block is idle.
// With the queue empty, an accepted item enters the queue, and its first output
// byte is then loaded into the output register, raising out_valid. An item whose
// text is N bytes holds the expander until all N bytes are loaded (a plain byte
// is shortest, a hex escape longest), so plain text flows at one byte per cycle
// while out_ready stays high; the queue of QUEUE_DEPTH items lets input be taken
// while a long entity is still being written out.
// Reset (rst_n low, synchronous) empties the queue and output register, clears
// attribute mode and the previous-byte context. When the receiver stalls, the
// output byte holds, the queue fills, and in_ready falls once it is full.
module xml_text_escaper_top #(
  parameter int QUEUE_DEPTH = xte_pkg::XTE_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_string_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last
);
  import xte_pkg::*;

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;
  xte_entry_t wr_entry;
  xte_entry_t rd_entry;

  xte_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .q_full          (q_full),
    .in_byte         (in_byte),
    .in_string_start (in_string_start),
    .in_ready        (in_ready),
    .push            (push),
    .entry           (wr_entry)
  );

  xte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_entry (rd_entry)
  );

  xte_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_entry      (rd_entry),
    .q_pop        (pop),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule

// ===== rtl/xte_front.sv =====
// Front end: accepts input items, tracks line-break context and classifies each byte.
`timescale 1ns / 1ps

module xte_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  input  logic              q_full,
  input  logic [7:0]        in_byte,
  input  logic              in_string_start,
  output logic              in_ready,
  output logic              push,
  output xte_pkg::xte_entry_t entry
);
  import xte_pkg::*;

  logic       attr_mode_r;
  logic [7:0] prev_r, prev_nxt;
  logic       have_prev_r, have_prev_nxt;
  logic       armed_r, armed_nxt;

  logic       accept;
  logic       is_nl;
  logic       drop;
  logic [7:0] prev_eff;
  logic       have_eff;
  logic       armed_eff;
  logic       armed_upd;
  logic [7:0] other;
  xte_kind_t  kind;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // A new string clears the previous-byte context and re-arms the break logic.
  always_comb begin
    prev_eff  = in_string_start ? 8'h00 : prev_r;
    have_eff  = in_string_start ? 1'b0 : have_prev_r;
    armed_eff = in_string_start ? 1'b1 : armed_r;
  end

  // CR/LF pairing: the complementary byte right after a line break is dropped once.
  always_comb begin
    is_nl     = (in_byte == CH_CR) || (in_byte == CH_LF);
    other     = (in_byte == CH_LF) ? CH_CR : CH_LF;
    armed_upd = armed_eff || (have_eff && prev_eff != CH_LF && prev_eff != CH_CR);
    drop      = is_nl && armed_upd && have_eff && (prev_eff == other);
    if (is_nl) begin
      armed_nxt = !drop;
    end else begin
      armed_nxt = armed_eff;
    end
    prev_nxt      = in_byte;
    have_prev_nxt = 1'b1;
  end

  // Classify the byte into the kind of text it turns into.
  always_comb begin
    if (is_nl) begin
      kind = attr_mode_r ? KIND_NL_ATTR : KIND_BR;
    end else if (in_byte == CH_LT) begin
      kind = KIND_LT;
    end else if (in_byte == CH_GT) begin
      kind = KIND_GT;
    end else if (in_byte == CH_AMP) begin
      kind = KIND_AMP;
    end else if (attr_mode_r && in_byte == CH_APOS) begin
      kind = KIND_APOS;
    end else if (attr_mode_r && in_byte == CH_QUOT) begin
      kind = KIND_QUOT;
    end else if (in_byte inside {CH_TAB, [8'h20:8'h7E]}) begin
      kind = KIND_PASS;
    end else begin
      kind = KIND_HEX;
    end
  end

  assign push       = accept && !drop;
  assign entry.kind = kind;
  assign entry.chr  = in_byte;

  // Context and mode registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_mode_r <= 1'b0;
      prev_r      <= 8'h00;
      have_prev_r <= 1'b0;
      armed_r     <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        attr_mode_r <= cfg_wr_data;
      end
      if (accept) begin
        prev_r      <= prev_nxt;
        have_prev_r <= have_prev_nxt;
        armed_r     <= armed_nxt;
      end
    end
  end

endmodule

// ===== rtl/xte_queue.sv =====
// Small FIFO of classified items between the front end and the back end.
`timescale 1ns / 1ps

module xte_queue #(
  parameter int DEPTH = xte_pkg::XTE_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  xte_pkg::xte_entry_t wr_entry,
  input  logic                pop,
  output logic                full,
  output logic                rd_valid,
  output xte_pkg::xte_entry_t rd_entry
);
  import xte_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  xte_entry_t       slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_entry = slot_r[rd_ptr_r];

  // Pointer wrap and occupancy update.
  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  // Item storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

`ifndef SYNTHESIS
  // An item is never written into a full queue unless one leaves in the same cycle.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && full |-> pop)
    else $error("queue overflow");

  // An item is never taken from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rd_valid)
    else $error("queue underflow");
`endif

endmodule

// ===== rtl/xte_back.sv =====
// Back end: expands each classified item into its run of output bytes.
`timescale 1ns / 1ps

module xte_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  xte_pkg::xte_entry_t q_entry,
  output logic                q_pop,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_run_last
);
  import xte_pkg::*;

  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic [3:0] len;
  logic       last;
  logic       load;

  // Load the next byte of the head item whenever the output register is free.
  always_comb begin
    len     = run_len(q_entry.kind);
    last    = (idx_r == len - 4'd1);
    load    = q_valid && (!out_valid_r || out_ready);
    idx_nxt = last ? 4'd0 : idx_r + 4'd1;
  end

  assign q_pop        = load && last;
  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 4'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= idx_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= run_byte(q_entry, idx_r);
      out_last_r <= last;
    end
  end

`ifndef SYNTHESIS
  // Partway through a run there is always an item at the queue head.
  a_run_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 4'd0 |-> q_valid)
    else $error("run in progress without an item");

  // The head item does not change while its run is being written out.
  a_head_stable: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 4'd0 |-> $stable(q_entry))
    else $error("head item changed during its run");

  // The run position never reaches the end of the current item's text.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> idx_r < len)
    else $error("run position past end of text");
`endif

endmodule

// ===== test/xml_text_escaper_top_test.sv =====
// Self-checking testbench for the XML text escaper top level.
`timescale 1ns / 1ps

module xml_text_escaper_top_test;
  import xte_pkg::*;

  // Cycles without any accepted item before the run is abandoned.
  localparam int IDLE_LIMIT = 4000;
  // Cycles allowed after the last expected byte for dropped newlines to retire.
  localparam int SETTLE_CYCLES = 32;
  localparam int REPORT_LIMIT = 10;

  // Characters that have an entity form in at least one mode.
  localparam logic [7:0] MARKUP_CHARS [5] = '{CH_LT, CH_GT, CH_AMP, CH_APOS, CH_QUOT};

  // One byte of escaped text together with its end-of-run flag.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h20;
  logic       in_string_start = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;

  // Predicted escaper state: attribute mode and newline-pairing context.
  logic       attr_mode_q = 1'b0;
  logic [7:0] prev_char = 8'h00;
  logic       have_prev = 1'b0;
  logic       break_armed = 1'b1;

  // Escaped text still owed by the block, oldest byte first.
  text_byte_t escaped_text[$];

  int mismatch_count = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;

  xml_text_escaper_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_string_start (in_string_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Count a failure and report the first few of them.
  function automatic void log_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s", $time, what);
    end
  endfunction

  // Queue a complete run of text; the last byte carries the end-of-run flag.
  function automatic void push_text(input string txt);
    text_byte_t tb;
    for (int i = 0; i < txt.len(); i++) begin
      tb.code = txt[i];
      tb.last = (i == txt.len() - 1);
      escaped_text.push_back(tb);
    end
  endfunction

  // Work out the escaped text for one accepted item and update the context.
  function automatic void predict_escape(input logic [7:0] c, input logic first);
    logic [7:0] partner;
    text_byte_t tb;
    if (first) begin
      have_prev = 1'b0;
      prev_char = 8'h00;
      break_armed = 1'b1;
    end
    if (c == CH_CR || c == CH_LF) begin
      partner = (c == CH_LF) ? CH_CR : CH_LF;
      if (have_prev && prev_char != CH_LF && prev_char != CH_CR) begin
        break_armed = 1'b1;
      end
      if (break_armed && have_prev && prev_char == partner) begin
        // The second half of a CR/LF pair is swallowed once.
        break_armed = 1'b0;
      end else begin
        break_armed = 1'b1;
        if (attr_mode_q) begin
          push_text("&#10;");
        end else begin
          push_text("<br/>");
        end
      end
    end else if (c == CH_LT) begin
      push_text("&lt;");
    end else if (c == CH_GT) begin
      push_text("&gt;");
    end else if (c == CH_AMP) begin
      push_text("&amp;");
    end else if (attr_mode_q && c == CH_APOS) begin
      push_text("&apos;");
    end else if (attr_mode_q && c == CH_QUOT) begin
      push_text("&quot;");
    end else if (c == CH_TAB || (c >= 8'h20 && c <= 8'h7E)) begin
      tb.code = c;
      tb.last = 1'b1;
      escaped_text.push_back(tb);
    end else begin
      push_text($sformatf("&lt;0x%02x&gt;", c));
    end
    prev_char = c;
    have_prev = 1'b1;
  endfunction

  // Idle length: mostly a few cycles, now and then a long one.
  function automatic int idle_gap();
    if ($urandom_range(0, 99) < 80) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Character mix for well-formed strings: text, markup, newlines, tabs, odd bytes.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return 8'($urandom_range(8'h20, 8'h7E));
    end
    if (r < 55) begin
      return MARKUP_CHARS[$urandom_range(0, 4)];
    end
    if (r < 75) begin
      return ($urandom_range(0, 1) == 1) ? CH_CR : CH_LF;
    end
    if (r < 80) begin
      return CH_TAB;
    end
    return 8'($urandom_range(1, 255));
  endfunction

  // Offer one item, wait for it to be taken, then maybe idle for a while.
  task automatic send_char(input logic [7:0] c, input logic first);
    int gap;
    in_valid <= 1'b1;
    in_byte <= c;
    in_string_start <= first;
    do @(posedge clk); while (!in_ready);
    predict_escape(c, first);
    gap = (sender_idles && $urandom_range(0, 2) == 0) ? idle_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until all owed text has arrived and dropped items have retired.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (escaped_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the attribute mode register; the caller ensures the block is idle.
  task automatic set_attr_mode(input logic mode);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    attr_mode_q = mode;
    cfg_wr_en <= 1'b0;
  endtask

  // Element text in the reset mode: extreme bytes, markup and newline pairs.
  task automatic test_plain_text();
    send_char(8'h41, 1'b1);
    send_char(8'h01, 1'b0);
    send_char(8'h1F, 1'b0);
    send_char(8'h20, 1'b0);
    send_char(8'h7E, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_TAB, 1'b0);
    for (int i = 0; i < 5; i++) begin
      send_char(MARKUP_CHARS[i], 1'b0);
    end
    // LF then CR drops the CR; a second CR is a new break whose LF drops.
    send_char(CH_LF, 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char(CH_LF, 1'b0);
    wait_until_idle();
  endtask

  // Attribute values: quotes, numeric newlines, and a CR/LF pair split by a pause.
  task automatic test_attribute_text();
    set_attr_mode(1'b1);
    send_char(CH_APOS, 1'b1);
    send_char(CH_QUOT, 1'b0);
    send_char(8'hAA, 1'b0);
    send_char(CH_CR, 1'b0);
    wait_until_idle();
    send_char(CH_LF, 1'b0);
    send_char(CH_LF, 1'b1);
    send_char(8'h55, 1'b0);
    wait_until_idle();
  endtask

  // Random strings in one mode, with some noise items and occasional full pauses.
  task automatic test_random_text(input logic mode, input int items);
    int sent;
    int len;
    wait_until_idle();
    set_attr_mode(mode);
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_char(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          send_char(pick_char(), i == 0);
        end
        sent += len;
      end
      if ($urandom_range(0, 19) == 0) begin
        wait_until_idle();
      end
    end
  endtask

  // Check each accepted output item and drive random back-pressure.
  always @(posedge clk) begin : check_output
    text_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (escaped_text.size() == 0) begin
        log_failure($sformatf("unexpected item: byte %h last %b", out_byte, out_run_last));
      end else begin
        want = escaped_text.pop_front();
        if (out_byte !== want.code) begin
          log_failure($sformatf("out_byte: expected %h, got %h", want.code, out_byte));
        end
        if (out_run_last !== want.last) begin
          log_failure($sformatf("out_run_last: expected %b, got %b (byte %h)",
                                want.last, out_run_last, want.code));
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
      stall_left = idle_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Abandon the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("xml_text_escaper_top_test: errors");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_text();
    test_attribute_text();
    test_random_text(1'b0, 110);
    test_random_text(1'b1, 110);
    // A stretch at full rate on both sides.
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random_text(1'b0, 50);
    receiver_idles = 1'b1;
    test_random_text(1'b1, 50);
    wait_until_idle();
    if (mismatch_count == 0 && escaped_text.size() == 0) begin
      $display("xml_text_escaper_top_test: clean");
    end else begin
      $display("xml_text_escaper_top_test: errors");
    end
    $finish;
  end

endmodule

// ===== xml_text_escaper_top.f =====
rtl/xte_pkg.sv
rtl/xte_front.sv
rtl/xte_queue.sv
rtl/xte_back.sv
rtl/xml_text_escaper_top.sv
test/xml_text_escaper_top_test.sv
